// ----- hdl/idll_pkg.sv -----
// ----------------------------------------------------------------------------
// idll_pkg: shared types and constants for the indexed doubly linked list
// Holds pool sizing, link encoding, opcodes, status codes, controller state
// and the command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idll_pkg;

    // Pool sizing; a link value of CAPACITY means null
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);

    // Fixed field widths of the stream items
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ELEM_W   = 5;
    localparam int CMP_W    = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

    // Opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_LINK_NEW,
        ST_LINK_NBR,
        ST_UNLINK,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic check;
        logic advance;
        logic link_new;
        logic link_nbr;
        logic unlink;
        logic load_result;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_remove;
        logic range_err;
        logic pool_full;
        logic walk_done;
        logic out_free;
    } stat_t;

    function automatic logic is_node(input logic [LINK_W-1:0] p);
        return p < NULL_LINK;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/idll_ctrl.sv -----
// ----------------------------------------------------------------------------
// idll_ctrl: operation sequencer
// Steps one transaction through check, walk, relink and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idll_ctrl
    import idll_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  s_tvalid,
    output logic s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.range_err || (!stat.is_remove && stat.pool_full))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = stat.is_remove ? ST_UNLINK : ST_LINK_NEW;
                end
            end
            ST_LINK_NEW:
            begin
                state_next = ST_LINK_NBR;
            end
            ST_LINK_NBR:
            begin
                state_next = ST_DONE;
            end
            ST_UNLINK:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
            end
            ST_WALK:
            begin
                cmd.advance = !stat.walk_done;
            end
            ST_LINK_NEW:
            begin
                cmd.link_new = 1'b1;
            end
            ST_LINK_NBR:
            begin
                cmd.link_nbr = 1'b1;
            end
            ST_UNLINK:
            begin
                cmd.unlink = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_result = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/idll_dp.sv -----
// ----------------------------------------------------------------------------
// idll_dp: list datapath
// Node pool memories, free map, head/tail/count, walk cursor and result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idll_dp
    import idll_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  cmd_t                       cmd,
    output stat_t                      stat,
    input  wire                        in_opcode,
    input  wire  [POS_W-1:0]           in_position,
    input  wire  signed [VALUE_W-1:0]  in_value,
    input  wire                        out_ready,
    output logic                       out_valid,
    output logic [STATUS_W-1:0]        out_status,
    output logic [ELEM_W-1:0]          out_count
);

    // Pool storage
    logic signed [VALUE_W-1:0] node_value [CAPACITY];
    logic [LINK_W-1:0]         next_link  [CAPACITY];
    logic [LINK_W-1:0]         prev_link  [CAPACITY];

    logic [CAPACITY-1:0]       free_reg;
    logic [CAPACITY-1:0]       free_next;
    logic [LINK_W-1:0]         head_reg;
    logic [LINK_W-1:0]         head_next;
    logic [LINK_W-1:0]         tail_reg;
    logic [LINK_W-1:0]         tail_next;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;

    // Item and walk state
    logic                      op_reg;
    logic [POS_W-1:0]          pos_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]          step_reg;
    logic [LINK_W-1:0]         cur_reg;
    logic [LINK_W-1:0]         cur_next;
    logic [IDX_W-1:0]          k_reg;
    logic [STATUS_W-1:0]       status_reg;

    logic [LINK_W-1:0]         nxt_rd_reg;
    logic [LINK_W-1:0]         prv_rd_reg;
    logic [IDX_W-1:0]          rd_addr;

    // Result register
    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [ELEM_W-1:0]         out_count_reg;

    // Write ports
    logic                      nl_we;
    logic [IDX_W-1:0]          nl_waddr;
    logic [LINK_W-1:0]         nl_wdata;
    logic                      pl_we;
    logic [IDX_W-1:0]          pl_waddr;
    logic [LINK_W-1:0]         pl_wdata;

    logic [IDX_W-1:0]          free_idx;
    logic                      pool_full;
    logic [LINK_W-1:0]         k_link;
    logic [LINK_W-1:0]         prev_node;
    logic [CMP_W-1:0]          pos_cmp;
    logic [CMP_W-1:0]          count_cmp;
    logic                      range_err;

    // Lowest free node
    always_comb
    begin
        free_idx = '0;
        for (int k = CAPACITY - 1; k >= 0; k--)
        begin
            if (free_reg[k])
            begin
                free_idx = IDX_W'(k);
            end
        end
    end

    assign pool_full = (free_reg == '0);
    assign k_link    = LINK_W'(k_reg);
    assign pos_cmp   = CMP_W'(pos_reg);
    assign count_cmp = CMP_W'(count_reg);
    assign range_err = (op_reg == OP_REMOVE) ? (pos_cmp >= count_cmp)
                                             : (pos_cmp >  count_cmp);
    assign prev_node = (op_reg == OP_INSERT && !is_node(cur_reg)) ? tail_reg : prv_rd_reg;

    assign stat.is_remove = (op_reg == OP_REMOVE);
    assign stat.range_err = range_err;
    assign stat.pool_full = pool_full;
    assign stat.walk_done = (step_reg == pos_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // Cursor: the link reads follow it, addressed by its next value
    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.check)
        begin
            cur_next = head_reg;
        end
        else if (cmd.advance)
        begin
            cur_next = nxt_rd_reg;
        end
    end

    assign rd_addr = is_node(cur_next) ? cur_next[IDX_W-1:0] : '0;

    // Relink writes and list pointers
    always_comb
    begin
        nl_we      = 1'b0;
        nl_waddr   = k_reg;
        nl_wdata   = cur_reg;
        pl_we      = 1'b0;
        pl_waddr   = k_reg;
        pl_wdata   = prev_node;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        count_next = count_reg;
        if (cmd.link_new)
        begin
            nl_we = 1'b1;
            pl_we = 1'b1;
        end
        else if (cmd.link_nbr)
        begin
            nl_waddr = prev_node[IDX_W-1:0];
            nl_wdata = k_link;
            pl_waddr = cur_reg[IDX_W-1:0];
            pl_wdata = k_link;
            if (is_node(prev_node))
            begin
                nl_we = 1'b1;
            end
            else
            begin
                head_next = k_link;
            end
            if (is_node(cur_reg))
            begin
                pl_we = 1'b1;
            end
            else
            begin
                tail_next = k_link;
            end
            free_next[k_reg] = 1'b0;
            count_next       = count_reg + 1'b1;
        end
        else if (cmd.unlink)
        begin
            nl_waddr = prev_node[IDX_W-1:0];
            nl_wdata = nxt_rd_reg;
            pl_waddr = nxt_rd_reg[IDX_W-1:0];
            pl_wdata = prev_node;
            if (is_node(prev_node))
            begin
                nl_we = 1'b1;
            end
            else
            begin
                head_next = nxt_rd_reg;
            end
            if (is_node(nxt_rd_reg))
            begin
                pl_we = 1'b1;
            end
            else
            begin
                tail_next = prev_node;
            end
            free_next[cur_reg[IDX_W-1:0]] = 1'b1;
            count_next                    = count_reg - 1'b1;
        end
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (nl_we)
        begin
            next_link[nl_waddr] <= nl_wdata;
        end
        if (pl_we)
        begin
            prev_link[pl_waddr] <= pl_wdata;
        end
        if (cmd.link_new)
        begin
            node_value[k_reg] <= value_reg;
        end
        nxt_rd_reg <= next_link[rd_addr];
        prv_rd_reg <= prev_link[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg      <= '1;
            head_reg      <= NULL_LINK;
            tail_reg      <= NULL_LINK;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_reg  <= free_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.load_item)
        begin
            op_reg    <= in_opcode;
            pos_reg   <= in_position;
            value_reg <= in_value;
        end
        if (cmd.check)
        begin
            step_reg <= '0;
            k_reg    <= free_idx;
            if (range_err)
            begin
                status_reg <= STAT_RANGE;
            end
            else if (op_reg == OP_INSERT && pool_full)
            begin
                status_reg <= STAT_FULL;
            end
            else
            begin
                status_reg <= STAT_OK;
            end
        end
        else if (cmd.advance)
        begin
            step_reg <= step_reg + 1'b1;
        end
        if (cmd.load_result)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= ELEM_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

// ----- hdl/indexed_doubly_linked_list_top.sv -----
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_top: doubly linked list in a fixed node pool
// Insert or remove at a 0-based position; one status transaction per item.
// ----------------------------------------------------------------------------
// Each input transaction inserts a value at a list position (tuser = 0) or
// removes the element at a position (tuser = 1), and yields exactly one
// output transaction with a status (ok, position out of range, pool full)
// and the element count after the operation. An error leaves the list
// unchanged; the range check comes before the full check. Inserts take the
// lowest-numbered free node. One item is worked at a time: the input is
// ready only while the sequencer is idle. An accepted item passes a check
// step, a walk and a relink step before its result; range and full errors
// go from the check straight to the result. The walk from head follows one
// next link per cycle out of the link memory; an insert relinks in a
// link-new step and then a link-neighbour step and a remove in its unlink
// step alone, because each link memory has a single write port. The result
// sits in an output register, so the next item is accepted while a result
// still waits to be taken; the sequencer only holds in its final step when
// the previous result is still waiting at that point. There is no clearing
// pass after reset: the free map is set to all free at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_doubly_linked_list_top
    import idll_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // position[4:0], item_value[36:5], zero pad
    input  wire         s_tuser,   // opcode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // element_count[4:0], zero pad
    output logic [1:0]  m_tuser    // status
);

    cmd_t              cmd;
    stat_t             stat;
    logic [ELEM_W-1:0] element_count;

    // Sequencer
    idll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Pool, pointers and result register
    idll_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_opcode   (s_tuser),
        .in_position (s_tdata[POS_W-1:0]),
        .in_value    (s_tdata[POS_W+VALUE_W-1:POS_W]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_count   (element_count)
    );

    // Pack the count into the low bits, zero the rest
    assign m_tdata = {{(8-ELEM_W){1'b0}}, element_count};

endmodule

`default_nettype wire
